// ===== rtl/ptpc_pkg.sv =====
// Shared codes, widths and controller/datapath interface types for the projection counter.
package ptpc_pkg;

	// Item kinds carried in the input tuser field
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTROID_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTROID_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd4;

	// Field widths
	localparam int OP_W      = 2;
	localparam int SIZE_W    = 11;
	localparam int THR_W     = 8;
	localparam int PIX_W     = 8;
	localparam int COL_IDX_W = 10;
	localparam int ROW_IDX_W = 10;
	localparam int CNT_W     = 11;
	localparam int QCNT_W    = 21;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;      // an input beat is accepted this cycle
		logic clr_step;  // zero one column store entry
		logic commit;    // update state and load the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_start;  // the offered beat is a frame start
		logic clr_last;  // the clearing sweep is on its last entry
	} sts_t;

	// One result item
	typedef struct packed {
		logic                 row_valid;
		logic [ROW_IDX_W-1:0] row_index;
		logic [CNT_W-1:0]     row_count;
		logic                 frame_valid;
		logic [QCNT_W-1:0]    top_left;
		logic [QCNT_W-1:0]    top_right;
		logic [QCNT_W-1:0]    bottom_left;
		logic [QCNT_W-1:0]    bottom_right;
		logic [QCNT_W-1:0]    frame_total;
		logic [CNT_W-1:0]     column_count;
	} res_t;

endpackage

// ===== rtl/ptpc_ctrl.sv =====
// Controller state machine: clearing sweep, item acceptance and output handoff.
module ptpc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  ptpc_pkg::sts_t  sts,
	output ptpc_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic       reply_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign out_free     = !out_valid_q || out_ready;
	assign cmd.take     = in_valid && (state_q == ST_IDLE);
	assign cmd.clr_step = (state_q == ST_CLEAR);
	assign cmd.commit   = (state_q == ST_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			reply_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= reply_q ? ST_EXEC : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.take) begin
						if (sts.is_start) begin
							state_q <= ST_CLEAR;
							reply_q <= 1'b1;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/ptpc_dp.sv =====
// Datapath: settings, counters, column count store and the output register.
module ptpc_dp #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ptpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [ptpc_pkg::OP_W-1:0]          in_op,
	input  logic [ptpc_pkg::PIX_W-1:0]         in_pixel,
	input  logic [ptpc_pkg::COL_IDX_W-1:0]     in_column_index,
	input  ptpc_pkg::cmd_t                     cmd,
	output ptpc_pkg::sts_t                     sts,
	output ptpc_pkg::res_t                     res
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_PIXEL = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	function automatic logic [ptpc_pkg::CNT_W-1:0] inc_cnt(
		input logic [ptpc_pkg::CNT_W-1:0] v
	);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [ptpc_pkg::QCNT_W-1:0] inc_qcnt(
		input logic [ptpc_pkg::QCNT_W-1:0] v
	);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [31:0] size_clamp(
		input logic [ptpc_pkg::SIZE_W-1:0] v,
		input int                          maxv
	);
		logic [31:0] r;
		r = 32'(v);
		if (v == '0) begin
			r = 32'd1;
		end else if (r > 32'(maxv)) begin
			r = 32'(maxv);
		end
		return r;
	endfunction

	// Configuration registers
	logic [ptpc_pkg::SIZE_W-1:0] width_q;
	logic [ptpc_pkg::SIZE_W-1:0] height_q;
	logic [ptpc_pkg::SIZE_W-1:0] cen_x_q;
	logic [ptpc_pkg::SIZE_W-1:0] cen_y_q;
	logic [ptpc_pkg::THR_W-1:0]  thr_cfg_q;

	// Frame state
	logic [XW-1:0]                 cx_q;
	logic [YW-1:0]                 cy_q;
	logic [ptpc_pkg::THR_W-1:0]    thr_q;
	logic [AW-1:0]                 col_pos_q;
	logic [HW-1:0]                 row_pos_q;
	logic [ptpc_pkg::CNT_W-1:0]    accum_q;
	logic [ptpc_pkg::QCNT_W-1:0]   quad_cnt_q [4];
	logic [ptpc_pkg::QCNT_W-1:0]   total_q;
	logic                          frame_done_q;
	logic [AW-1:0]                 clr_cnt_q;

	// Item in flight
	logic [1:0] kind_q;
	logic       hit_q;
	logic [1:0] quad_q;
	logic       row_end_q;
	logic       frame_end_q;
	logic       read_ok_q;

	// Column store
	logic [ptpc_pkg::CNT_W-1:0] mem_q [MAX_WIDTH];
	logic [ptpc_pkg::CNT_W-1:0] rd_data_q;

	logic [1:0]                  kind_c;
	logic                        row_end_c;
	logic                        frame_end_c;
	logic [1:0]                  quad_c;
	logic [AW-1:0]               rd_addr_c;
	logic [31:0]                 w_cl;
	logic [31:0]                 h_cl;
	logic                        pix_cnt;
	logic                        col_we;
	logic [ptpc_pkg::QCNT_W-1:0] quad_nx [4];
	logic [ptpc_pkg::QCNT_W-1:0] total_nx;
	logic [ptpc_pkg::CNT_W-1:0]  accum_nx;
	ptpc_pkg::res_t              res_c;
	ptpc_pkg::res_t              res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 11'd640;
			height_q  <= 11'd480;
			cen_x_q   <= '0;
			cen_y_q   <= '0;
			thr_cfg_q <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptpc_pkg::REG_FRAME_WIDTH:  width_q   <= cfg_data;
				ptpc_pkg::REG_FRAME_HEIGHT: height_q  <= cfg_data;
				ptpc_pkg::REG_CENTROID_X:   cen_x_q   <= cfg_data;
				ptpc_pkg::REG_CENTROID_Y:   cen_y_q   <= cfg_data;
				ptpc_pkg::REG_THRESHOLD:    thr_cfg_q <= cfg_data[ptpc_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Decisions taken when a beat is accepted; the state they read holds until commit.
	always_comb begin
		case (in_op)
			ptpc_pkg::OP_START: kind_c = KIND_START;
			ptpc_pkg::OP_PIXEL: kind_c = frame_done_q ? KIND_NONE : KIND_PIXEL;
			ptpc_pkg::OP_READ:  kind_c = KIND_READ;
			default:            kind_c = KIND_NONE;
		endcase
	end

	assign row_end_c = (width_q == '0)
		|| (32'(col_pos_q) + 32'd1 >= 32'(width_q))
		|| (col_pos_q == AW'(MAX_WIDTH - 1));
	assign frame_end_c = (height_q == '0)
		|| (32'(row_pos_q) + 32'd1 >= 32'(height_q))
		|| (row_pos_q == HW'(MAX_HEIGHT - 1));
	assign quad_c = {32'(row_pos_q) >= 32'(cy_q), 32'(col_pos_q) >= 32'(cx_q)};
	assign rd_addr_c = (in_op == ptpc_pkg::OP_READ) ? AW'(in_column_index) : col_pos_q;
	assign w_cl = size_clamp(width_q, MAX_WIDTH);
	assign h_cl = size_clamp(height_q, MAX_HEIGHT);

	assign sts.is_start = (in_op == ptpc_pkg::OP_START);
	assign sts.clr_last = (clr_cnt_q == AW'(MAX_WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (cmd.take) begin
			kind_q <= kind_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			hit_q       <= in_pixel > thr_q;
			quad_q      <= quad_c;
			row_end_q   <= row_end_c;
			frame_end_q <= frame_end_c;
			read_ok_q   <= 32'(in_column_index) < 32'(MAX_WIDTH);
		end
	end

	// Values after the counted pixel, shown on the result of the same item.
	assign pix_cnt = (kind_q == KIND_PIXEL) && hit_q;
	assign col_we  = cmd.commit && pix_cnt;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			quad_nx[i] = (pix_cnt && quad_q == 2'(i)) ? inc_qcnt(quad_cnt_q[i]) : quad_cnt_q[i];
		end
	end

	assign total_nx = pix_cnt ? inc_qcnt(total_q) : total_q;
	assign accum_nx = pix_cnt ? inc_cnt(accum_q) : accum_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rd_data_q <= mem_q[rd_addr_c];
		end
		if (cmd.clr_step) begin
			mem_q[clr_cnt_q] <= '0;
		end else if (col_we) begin
			mem_q[col_pos_q] <= inc_cnt(rd_data_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.take && sts.is_start) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q         <= '0;
			cy_q         <= '0;
			thr_q        <= '0;
			col_pos_q    <= '0;
			row_pos_q    <= '0;
			accum_q      <= '0;
			total_q      <= '0;
			frame_done_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				quad_cnt_q[i] <= '0;
			end
		end else if (cmd.take && sts.is_start) begin
			cx_q         <= (32'(cen_x_q) > w_cl) ? XW'(w_cl) : XW'(cen_x_q);
			cy_q         <= (32'(cen_y_q) > h_cl) ? YW'(h_cl) : YW'(cen_y_q);
			thr_q        <= thr_cfg_q;
			col_pos_q    <= '0;
			row_pos_q    <= '0;
			accum_q      <= '0;
			total_q      <= '0;
			frame_done_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				quad_cnt_q[i] <= '0;
			end
		end else if (cmd.commit && kind_q == KIND_PIXEL) begin
			total_q <= total_nx;
			for (int i = 0; i < 4; i++) begin
				quad_cnt_q[i] <= quad_nx[i];
			end
			if (row_end_q) begin
				accum_q   <= '0;
				col_pos_q <= '0;
				if (frame_end_q) begin
					row_pos_q    <= '0;
					frame_done_q <= 1'b1;
				end else begin
					row_pos_q <= row_pos_q + HW'(1);
				end
			end else begin
				accum_q   <= accum_nx;
				col_pos_q <= col_pos_q + AW'(1);
			end
		end
	end

	always_comb begin
		res_c = '0;
		case (kind_q)
			KIND_PIXEL: begin
				if (row_end_q) begin
					res_c.row_valid = 1'b1;
					res_c.row_index = ptpc_pkg::ROW_IDX_W'(row_pos_q);
					res_c.row_count = accum_nx;
					if (frame_end_q) begin
						res_c.frame_valid  = 1'b1;
						res_c.top_left     = quad_nx[0];
						res_c.top_right    = quad_nx[1];
						res_c.bottom_left  = quad_nx[2];
						res_c.bottom_right = quad_nx[3];
						res_c.frame_total  = total_nx;
					end
				end
			end
			KIND_READ: begin
				res_c.column_count = read_ok_q ? rd_data_q : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= res_c;
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/pixel_threshold_projection_counter.sv =====
// Top level of the thresholded pixel projection counter.
//
// Input beats carry a kind in s_axis_tuser: frame start, pixel or column read.
// Pixels arrive in raster order; a pixel above the latched threshold adds one
// to its column count, its quadrant count and the running row count. The
// pixel that ends a row returns the row count, the one that ends the frame
// also returns the four quadrant counts and their total. Every beat accepted
// returns exactly one result beat on the m_axis side.
// A pixel or read beat is first accepted, then the column store does its
// read-modify-write through its single registered read port, once the output
// register is free. The result is valid from the cycle after that update.
// A frame start sweeps the column store to zero, one entry per cycle, before
// its all-zero result is shown.
// Reset clears the counters and runs the same sweep, during which
// s_axis_tready stays low; configuration writes are taken then.
// A result waits in the output register while the receiver stalls; the next
// beat is still accepted, but its update and handoff wait until it is taken.
module pixel_threshold_projection_counter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port
	input  logic                            cfg_we,
	input  logic [ptpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptpc_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [23:0]                     s_axis_tdata,  // pixel[7:0], column_index[17:8]
	input  logic [1:0]                      s_axis_tuser,  // op[1:0]
	// Result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// row_index[9:0], row_count[20:10], top_left[41:21], top_right[62:42],
	// bottom_left[83:63], bottom_right[104:84], frame_total[125:105],
	// column_count[136:126]
	output logic [143:0]                    m_axis_tdata,
	output logic [1:0]                      m_axis_tuser   // row_valid[0], frame_valid[1]
);

	ptpc_pkg::cmd_t cmd;
	ptpc_pkg::sts_t sts;
	ptpc_pkg::res_t res;

	// The controller only sequences; all counting lives in the datapath.
	ptpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptpc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_op           (s_axis_tuser),
		.in_pixel        (s_axis_tdata[7:0]),
		.in_column_index (s_axis_tdata[17:8]),
		.cmd             (cmd),
		.sts             (sts),
		.res             (res)
	);

	// Pack the result fields, lowest field in the lowest bits, zero padded.
	assign m_axis_tdata = {7'd0, res.column_count, res.frame_total, res.bottom_right,
		res.bottom_left, res.top_right, res.top_left, res.row_count, res.row_index};
	assign m_axis_tuser = {res.frame_valid, res.row_valid};

	// An accepted beat keeps the input closed for at least the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an item is still in work");

	// The clearing sweep never overlaps acceptance of a beat.
	a_clear_closed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !s_axis_tready)
		else $error("input open during column store sweep");

	// A new result is only loaded once the waiting one has been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten before it was taken");

	// The end of a frame is always also the end of a row.
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
		else $error("frame result without row result");

endmodule

// ===== tb/sv/projection_checker.sv =====
// Watches the projection counter's channels, predicts every result beat and compares it.
module projection_checker
	import ptpc_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [23:0]           s_tdata,   // pixel[7:0], column_index[17:8]
	input  logic [1:0]            s_tuser,   // op[1:0]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// row_index, row_count, top_left, top_right, bottom_left, bottom_right,
	// frame_total, column_count
	input  logic [143:0]          m_tdata,
	input  logic [1:0]            m_tuser,   // row_valid[0], frame_valid[1]
	output int                    errors
);

	// Live register copies
	logic [SIZE_W-1:0]    reg_width, reg_height, reg_cx, reg_cy;
	logic [THR_W-1:0]     reg_thr;

	// Own copy of the counting state
	logic [CNT_W-1:0]     col_store [MAX_WIDTH];
	logic [COL_IDX_W-1:0] col_pos;
	logic [ROW_IDX_W-1:0] row_pos;
	logic [CNT_W-1:0]     row_accum;
	logic [QCNT_W-1:0]    quad [4];
	logic [SIZE_W-1:0]    lat_cx, lat_cy;
	logic [THR_W-1:0]     lat_thr;
	logic                 frame_done;

	res_t expected_counts [$];

	initial errors = 0;

	function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
		if (v == '0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [QCNT_W-1:0] got_v,
			input logic [QCNT_W-1:0] want_v);
		if (got_v !== want_v)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
	endtask

	task automatic clear_frame();
		for (int i = 0; i < MAX_WIDTH; i++)
			col_store[i] = '0;
		for (int i = 0; i < 4; i++)
			quad[i] = '0;
		col_pos    = '0;
		row_pos    = '0;
		row_accum  = '0;
		frame_done = 1'b0;
	endtask

	// Advances the counting state by one beat and yields the result it gives.
	task automatic project_beat(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix,
			input logic [COL_IDX_W-1:0] col, output res_t r);
		int w;
		int h;
		int c;
		int q;
		logic [QCNT_W+1:0] quad_sum;
		r = '0;
		w = clamp_size(reg_width, MAX_WIDTH);
		h = clamp_size(reg_height, MAX_HEIGHT);
		case (op)
			OP_START: begin
				clear_frame();
				lat_cx  = (int'(reg_cx) > w) ? SIZE_W'(w) : reg_cx;
				lat_cy  = (int'(reg_cy) > h) ? SIZE_W'(h) : reg_cy;
				lat_thr = reg_thr;
			end
			OP_READ: begin
				if (int'(col) < MAX_WIDTH)
					r.column_count = col_store[col];
			end
			OP_PIXEL: begin
				if (!frame_done) begin
					c = (int'(col_pos) < MAX_WIDTH) ? int'(col_pos) : MAX_WIDTH - 1;
					if (pix > lat_thr) begin
						q = ((int'(row_pos) < int'(lat_cy)) ? 0 : 2) + ((c < int'(lat_cx)) ? 0 : 1);
						col_store[c] = col_store[c] + (col_store[c] != '1);
						quad[q]      = quad[q] + (quad[q] != '1);
						row_accum    = row_accum + (row_accum != '1);
					end
					if (int'(col_pos) + 1 >= w) begin
						r.row_valid = 1'b1;
						r.row_index = row_pos;
						r.row_count = row_accum;
						row_accum   = '0;
						col_pos     = '0;
						if (int'(row_pos) + 1 >= h) begin
							quad_sum       = quad[0] + quad[1] + quad[2] + quad[3];
							r.frame_valid  = 1'b1;
							r.top_left     = quad[0];
							r.top_right    = quad[1];
							r.bottom_left  = quad[2];
							r.bottom_right = quad[3];
							r.frame_total  = (quad_sum > {2'b00, {QCNT_W{1'b1}}}) ?
								'1 : quad_sum[QCNT_W-1:0];
							row_pos        = '0;
							frame_done     = 1'b1;
						end else begin
							row_pos = row_pos + 1'b1;
						end
					end else begin
						col_pos = col_pos + 1'b1;
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : watch
		res_t want;
		res_t got;
		if (!arst_n) begin
			reg_width  = SIZE_W'(640);
			reg_height = SIZE_W'(480);
			reg_cx     = '0;
			reg_cy     = '0;
			reg_thr    = THR_W'(128);
			clear_frame();
			lat_cx     = '0;
			lat_cy     = '0;
			lat_thr    = '0;
			expected_counts.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  reg_width  = cfg_data;
					REG_FRAME_HEIGHT: reg_height = cfg_data;
					REG_CENTROID_X:   reg_cx     = cfg_data;
					REG_CENTROID_Y:   reg_cy     = cfg_data;
					REG_THRESHOLD:    reg_thr    = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				project_beat(s_tuser, s_tdata[7:0], s_tdata[17:8], want);
				expected_counts.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.row_valid    = m_tuser[0];
				got.frame_valid  = m_tuser[1];
				got.row_index    = m_tdata[9:0];
				got.row_count    = m_tdata[20:10];
				got.top_left     = m_tdata[41:21];
				got.top_right    = m_tdata[62:42];
				got.bottom_left  = m_tdata[83:63];
				got.bottom_right = m_tdata[104:84];
				got.frame_total  = m_tdata[125:105];
				got.column_count = m_tdata[136:126];
				if (expected_counts.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = expected_counts.pop_front();
					check_field("row_valid", got.row_valid, want.row_valid);
					check_field("row_index", got.row_index, want.row_index);
					check_field("row_count", got.row_count, want.row_count);
					check_field("frame_valid", got.frame_valid, want.frame_valid);
					check_field("top_left", got.top_left, want.top_left);
					check_field("top_right", got.top_right, want.top_right);
					check_field("bottom_left", got.bottom_left, want.bottom_left);
					check_field("bottom_right", got.bottom_right, want.bottom_right);
					check_field("frame_total", got.frame_total, want.frame_total);
					check_field("column_count", got.column_count, want.column_count);
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Stimulus and verdict for the thresholded pixel projection counter.
module tb;
	import ptpc_pkg::*;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	// Total input beats after which the random part stops offering new frames.
	localparam int ITEMS_TOTAL = 950;
	// Length of the one long receiver hold-off, in cycles.
	localparam int STALL_LEN   = 300;
	// Fixed end of the run; the run time is dominated by the column store sweep
	// of every frame start.
	localparam int LIMIT_TIME  = 4000000;

	// The op code that the block must ignore, and a register index that holds nothing.
	localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;
	logic [1:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [143:0]          m_tdata;
	logic [1:0]            m_tuser;

	int errors;
	int sent_count    = 0;   // input beats accepted, kept by the stimulus process
	int recv_count    = 0;   // result beats taken, kept by the receiver process
	int send_idle_pct = 10;
	int recv_idle_pct = 45;
	int stall_reqs    = 0;
	int stall_seen    = 0;
	int stall_left    = 0;

	pixel_threshold_projection_counter #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata),
		.m_axis_tuser (m_tuser)
	);

	projection_checker #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: takes result beats with random back-pressure. When the stimulus
	// asks for a hold-off, tready stays low while the STALL_LEN countdown kept
	// here runs, so that the output register fills and the block has to stall its input.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			recv_count <= recv_count + 1;
		if (stall_reqs != stall_seen) begin
			stall_seen = stall_reqs;
			stall_left = STALL_LEN;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offers one input beat, with random idle cycles before it, and returns in the
	// time step of the edge at which it was taken. tvalid is left high so that a
	// following beat goes out back to back; whoever stops sending lowers it.
	task automatic send_beat(input logic [OP_W-1:0] op, input int pix, input int col);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'd0, COL_IDX_W'(col), PIX_W'(pix)};
		do
			@(posedge clk);
		while (!s_tready);
		sent_count++;
	endtask

	// Stops offering and waits until every accepted beat has had its result,
	// then waits out the extra cycles asked for.
	task automatic settle(input int extra_cycles);
		s_tvalid <= 1'b0;
		while (recv_count != sent_count)
			@(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	// Drives one register write; the caller lowers the write enable afterwards.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
	endtask

	// Rewrites every register while the block is idle.
	task automatic apply_settings(input int w, input int h, input int cx, input int cy,
			input int thr, input bit poke_unused);
		settle(8);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_CENTROID_X, cx);
		write_reg(REG_CENTROID_Y, cy);
		write_reg(REG_THRESHOLD, thr);
		if (poke_unused)
			write_reg(REG_UNUSED, 2047);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int  w;
		int  h;
		int  w_eff;
		int  h_eff;
		int  cx;
		int  cy;
		int  thr;
		int  n_pix;
		int  noise;
		int  pix;
		bit  stall_done;
		stall_done = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Pixels straight after reset count against the reset latch values: a
		// zero threshold and the reset frame size, with no frame start yet.
		send_beat(OP_PIXEL, 0, 0);
		send_beat(OP_PIXEL, 255, 1023);
		send_beat(OP_READ, 0, 1);
		send_beat(OP_READ, 255, 1023);
		send_beat(OP_UNUSED, 255, 1023);

		// A small 3 by 2 frame split at (1, 1); pixels at the threshold must not
		// count, one above must. Then a pixel after the frame ended, and reads.
		apply_settings(3, 2, 1, 1, 128, 1'b1);
		send_beat(OP_START, 255, 1023);
		send_beat(OP_PIXEL, 128, 0);
		send_beat(OP_PIXEL, 129, 0);
		send_beat(OP_PIXEL, 255, 0);
		send_beat(OP_PIXEL, 0, 0);
		send_beat(OP_PIXEL, 200, 0);
		send_beat(OP_PIXEL, 129, 0);
		send_beat(OP_PIXEL, 255, 0);
		send_beat(OP_READ, 0, 0);
		send_beat(OP_READ, 0, 1);
		send_beat(OP_READ, 0, 2);
		send_beat(OP_UNUSED, 0, 0);

		// Zero sizes act as one pixel, the centroid is clamped to the size, and
		// with the top threshold nothing can count.
		apply_settings(0, 0, 2047, 2047, 255, 1'b0);
		send_beat(OP_START, 0, 0);
		send_beat(OP_PIXEL, 255, 0);
		send_beat(OP_PIXEL, 254, 0);

		// Oversized settings clamp to the largest frame; only its start is used.
		apply_settings(2047, 2047, 1024, 1024, 0, 1'b0);
		send_beat(OP_START, 0, 0);
		send_beat(OP_PIXEL, 1, 0);
		send_beat(OP_PIXEL, 0, 0);
		send_beat(OP_READ, 0, 0);
		send_beat(OP_READ, 0, 1);

		// Random frames: mostly well-formed, small frames with random content,
		// with reads, ignored ops and stray frame starts mixed in as noise.
		while (sent_count < ITEMS_TOTAL) begin
			if ($urandom_range(11) == 0) begin
				case ($urandom_range(2))
					0:       w = 0;
					1:       w = MAX_WIDTH;
					default: w = 2047;
				endcase
			end else begin
				w = $urandom_range(12, 1);
			end
			if ($urandom_range(11) == 0) begin
				case ($urandom_range(2))
					0:       h = 0;
					1:       h = MAX_HEIGHT;
					default: h = 2047;
				endcase
			end else begin
				h = $urandom_range(8, 1);
			end
			w_eff = (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
			h_eff = (h < 1) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
			cx = ($urandom_range(7) == 0) ? int'($urandom_range(2047)) :
				int'($urandom_range(w_eff + 1));
			cy = ($urandom_range(7) == 0) ? int'($urandom_range(2047)) :
				int'($urandom_range(h_eff + 1));
			if ($urandom_range(5) == 0)
				thr = $urandom_range(1) ? 255 : 0;
			else
				thr = $urandom_range(255);

			apply_settings(w, h, cx, cy, thr, 1'b0);

			// The idling pattern changes by thirds of the run.
			if (sent_count < 330) begin
				send_idle_pct = 10;
				recv_idle_pct <= 45;
			end else if (sent_count < 640) begin
				send_idle_pct = 45;
				recv_idle_pct <= 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end

			// Now and then the frame runs on without a new start, under the new
			// live frame size.
			if ($urandom_range(6) != 0)
				send_beat(OP_START, $urandom_range(255), $urandom_range(1023));

			n_pix = w_eff * h_eff;
			if (n_pix > 60)
				n_pix = $urandom_range(60, 20);
			if ($urandom_range(7) == 0)
				n_pix = $urandom_range(n_pix);
			else if ($urandom_range(3) == 0)
				n_pix = n_pix + $urandom_range(2, 1);

			for (int k = 0; k < n_pix; k++) begin
				noise = $urandom_range(99);
				if (noise < 6)
					send_beat(OP_READ, $urandom_range(255), $urandom_range(1)
						? int'($urandom_range(w_eff - 1)) : int'($urandom_range(1023)));
				else if (noise < 8)
					send_beat(OP_UNUSED, $urandom_range(255), $urandom_range(1023));
				else if (noise < 9)
					send_beat(OP_START, $urandom_range(255), $urandom_range(1023));

				// Half the pixels sit close to the threshold to exercise the
				// strict comparison.
				if ($urandom_range(1)) begin
					pix = $urandom_range(255);
				end else begin
					pix = thr + int'($urandom_range(4)) - 2;
					pix = (pix < 0) ? 0 : ((pix > 255) ? 255 : pix);
				end
				send_beat(OP_PIXEL, pix, $urandom_range(1023));

				// One long hold-off by the receiver while pixels keep coming.
				if (!stall_done && sent_count >= 500) begin
					stall_reqs <= stall_reqs + 1;
					stall_done = 1'b1;
				end
			end

			repeat ($urandom_range(3))
				send_beat(OP_READ, $urandom_range(255), $urandom_range(1)
					? int'($urandom_range(w_eff - 1)) : int'($urandom_range(1023)));
		end

		settle(20);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#LIMIT_TIME;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
